// File: rtl/itp_pkg.sv
// Shared types, codes and helpers for the infix-to-postfix converter.
// No dependencies; every module file of the block imports this package; the interfaces do not.
`default_nettype none
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int NUM_OPS_DEF     = 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_W           = 24;
    localparam int VALUE_W         = 32;
    localparam int CODE_W          = 3;
    localparam int PRIO_W          = 3;
    localparam int BRK_BIT         = 3;

    // input token kinds
    localparam logic [2:0] TK_NUM   = 3'd0;
    localparam logic [2:0] TK_OP    = 3'd1;
    localparam logic [2:0] TK_OPEN  = 3'd2;
    localparam logic [2:0] TK_CLOSE = 3'd3;

    typedef enum logic [2:0] {
        CLS_NUM,
        CLS_OP,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_BAD
    } t_cls;

    typedef enum logic [1:0] {
        OK_NUM,
        OK_OP,
        OK_BRK,
        OK_ERR
    } t_okind;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_BRACKET,
        ERR_TOKEN,
        ERR_OVERFLOW
    } t_err;

    typedef enum logic [1:0] {
        ST_TOKEN,
        ST_CLOSE,
        ST_FLUSH,
        ST_FIN
    } t_state;

    typedef logic [CFG_W-1:0]  t_prio_cfg;
    typedef logic [CODE_W:0]   t_entry;    // bracket mark on top of the operator code

    typedef struct packed {
        t_cls               cls;
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
        logic               endf;
    } t_cmd;

    typedef struct packed {
        t_okind             kind;
        logic [VALUE_W-1:0] value;
        t_err               err;
    } t_res;

    function automatic logic [PRIO_W-1:0] prio_of(input t_prio_cfg cfg,
                                                  input logic [CODE_W-1:0] code);
        logic [4:0] base;
        base    = {2'b00, code} * 5'd3;
        prio_of = cfg[base +: PRIO_W];
    endfunction

    function automatic t_res entry_res(input t_entry e);
        t_res r;
        r.err = ERR_NONE;
        if (e[BRK_BIT]) begin
            r.kind  = OK_BRK;
            r.value = '0;
        end else begin
            r.kind  = OK_OP;
            r.value = {{(VALUE_W-CODE_W){1'b0}}, e[CODE_W-1:0]};
        end
        return r;
    endfunction

    function automatic t_res err_res(input t_err code);
        t_res r;
        r.kind  = OK_ERR;
        r.value = {{(VALUE_W-2){1'b0}}, code};
        r.err   = code;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/itp_tok_if.sv
// Token input channel: valid/ready plus one classified token.
// Depends on nothing.
`default_nettype none
interface itp_tok_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [31:0] token_value;
    logic        end_of_expr;

    modport source (output valid, output token_kind, output token_value,
                    output end_of_expr, input ready);
    modport sink   (input valid, input token_kind, input token_value,
                    input end_of_expr, output ready);
endinterface
`default_nettype wire

// File: rtl/itp_res_if.sv
// Result output channel: valid/ready plus one postfix result.
// Depends on nothing.
`default_nettype none
interface itp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [31:0] out_value;
    logic [1:0]  error_code;
    logic        last;

    modport source (output valid, output out_kind, output out_value,
                    output error_code, output last, input ready);
    modport sink   (input valid, input out_kind, input out_value,
                    input error_code, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/itp_cfg_if.sv
// Configuration write channel: valid/ready plus the priority table word.
// Depends on nothing.
`default_nettype none
interface itp_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] op_priorities;

    modport source (output valid, output op_priorities, input ready);
    modport sink   (input valid, input op_priorities, output ready);
endinterface
`default_nettype wire

// File: rtl/itp_front.sv
// Front end: accepts token beats, classifies them, holds the priority table.
// Depends on itp_pkg, itp_tok_if, itp_cfg_if.
`default_nettype none
module itp_front #(
    parameter int NUM_OPS = itp_pkg::NUM_OPS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    itp_tok_if.sink          i_tok,
    itp_cfg_if.sink          i_cfg,
    output logic             o_cmd_valid,
    output itp_pkg::t_cmd    o_cmd,
    input  wire              i_cmd_ready,
    output itp_pkg::t_prio_cfg o_prio
);
    import itp_pkg::*;

    t_prio_cfg          r_prio;
    logic [CODE_W-1:0]  code;
    logic               code_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio <= '0;
        end else if (i_cfg.valid) begin
            r_prio <= i_cfg.op_priorities;
        end
    end

    assign i_cfg.ready = 1'b1;
    assign o_prio      = r_prio;

    assign code     = i_tok.token_value[CODE_W-1:0];
    assign code_bad = {1'b0, code} >= (CODE_W+1)'(NUM_OPS);

    always_comb begin
        o_cmd.value = i_tok.token_value;
        o_cmd.endf  = i_tok.end_of_expr;
        o_cmd.prio  = prio_of(r_prio, code);
        case (i_tok.token_kind)
            TK_NUM:   o_cmd.cls = CLS_NUM;
            TK_OP:    o_cmd.cls = code_bad ? CLS_BAD : CLS_OP;
            TK_OPEN:  o_cmd.cls = CLS_OPEN;
            TK_CLOSE: o_cmd.cls = CLS_CLOSE;
            default:  o_cmd.cls = CLS_BAD;
        endcase
    end

    assign o_cmd_valid = i_tok.valid;
    assign i_tok.ready = i_cmd_ready;

endmodule
`default_nettype wire

// File: rtl/itp_queue.sv
// Short command queue between the front end and the stack engine.
// Depends on itp_pkg.
`default_nettype none
module itp_queue (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  itp_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output itp_pkg::t_cmd o_cmd,
    input  wire           i_pop
);
    import itp_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_cmd           r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr, n_wr;
    logic [QAW-1:0] r_rd, n_rd;
    logic [QCW-1:0] r_cnt, n_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_ready = r_cnt != QCW'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QAW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QAW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + QCW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// File: rtl/itp_back.sv
// Stack engine: runs shunting-yard steps on queued commands, owns the
// operator stack memory and the result output register.
// Depends on itp_pkg, itp_res_if.
`default_nettype none
module itp_back #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  itp_pkg::t_prio_cfg i_prio,
    input  wire                i_q_valid,
    input  itp_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    itp_res_if.source          o_res
);
    import itp_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_entry            r_mem [STACK_DEPTH];
    t_entry            r_top;
    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_err, n_err;
    t_res              r_pend, n_pend;
    logic              r_pend_v, n_pend_v;
    t_res              r_out, n_out;
    logic              r_out_last, n_out_last;
    logic              r_ov, n_ov;

    t_cmd              c;
    logic              out_free;
    logic              emit_ok;
    logic              do_emit;
    logic              do_fin;
    t_res              emit_res;
    t_res              top_res;
    logic [PRIO_W-1:0] top_prio;
    logic              stack_empty;
    logic              stack_full;
    logic              we;
    t_entry            wdata;
    logic [CW-1:0]     rd_tmp;
    logic [AW-1:0]     rd_addr;
    t_state            st_done;

    assign c           = i_q_cmd;
    assign out_free    = !r_ov || o_res.ready;
    assign emit_ok     = !r_pend_v || out_free;
    assign top_res     = entry_res(r_top);
    assign top_prio    = prio_of(i_prio, r_top[CODE_W-1:0]);
    assign stack_empty = r_count == '0;
    assign stack_full  = r_count == CW'(STACK_DEPTH);
    assign st_done     = c.endf ? ST_FLUSH : ST_FIN;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_err    = r_err;
        do_emit  = 1'b0;
        do_fin   = 1'b0;
        emit_res = '0;
        we       = 1'b0;
        wdata    = '0;
        o_q_pop  = 1'b0;

        case (r_state)
            ST_TOKEN: begin
                if (i_q_valid) begin
                    if (r_err) begin
                        o_q_pop = 1'b1;
                        if (c.endf) begin
                            n_err = 1'b0;
                        end
                    end else begin
                        case (c.cls)
                            CLS_NUM: begin
                                if (emit_ok) begin
                                    do_emit        = 1'b1;
                                    emit_res.kind  = OK_NUM;
                                    emit_res.value = c.value;
                                    emit_res.err   = ERR_NONE;
                                    o_q_pop        = 1'b1;
                                    n_state        = st_done;
                                end
                            end
                            CLS_OP: begin
                                if (!stack_empty && !r_top[BRK_BIT] && top_prio >= c.prio) begin
                                    if (emit_ok) begin
                                        do_emit  = 1'b1;
                                        emit_res = top_res;
                                        n_count  = r_count - CW'(1);
                                    end
                                end else if (stack_full) begin
                                    if (emit_ok) begin
                                        do_emit  = 1'b1;
                                        emit_res = err_res(ERR_OVERFLOW);
                                        n_count  = '0;
                                        n_err    = 1'b1;
                                        o_q_pop  = 1'b1;
                                        n_state  = st_done;
                                    end
                                end else begin
                                    we      = 1'b1;
                                    wdata   = {1'b0, c.value[CODE_W-1:0]};
                                    n_count = r_count + CW'(1);
                                    o_q_pop = 1'b1;
                                    n_state = st_done;
                                end
                            end
                            CLS_OPEN: begin
                                if (stack_full) begin
                                    if (emit_ok) begin
                                        do_emit  = 1'b1;
                                        emit_res = err_res(ERR_OVERFLOW);
                                        n_count  = '0;
                                        n_err    = 1'b1;
                                        o_q_pop  = 1'b1;
                                        n_state  = st_done;
                                    end
                                end else begin
                                    we      = 1'b1;
                                    wdata   = {1'b1, {CODE_W{1'b0}}};
                                    n_count = r_count + CW'(1);
                                    o_q_pop = 1'b1;
                                    n_state = st_done;
                                end
                            end
                            CLS_CLOSE: begin
                                if (stack_empty) begin
                                    if (emit_ok) begin
                                        do_emit  = 1'b1;
                                        emit_res = err_res(ERR_BRACKET);
                                        n_err    = 1'b1;
                                        o_q_pop  = 1'b1;
                                        n_state  = st_done;
                                    end
                                end else if (r_top[BRK_BIT]) begin
                                    n_count = r_count - CW'(1);
                                    o_q_pop = 1'b1;
                                    n_state = st_done;
                                end else if (emit_ok) begin
                                    do_emit  = 1'b1;
                                    emit_res = top_res;
                                    n_count  = r_count - CW'(1);
                                    n_state  = ST_CLOSE;
                                end
                            end
                            default: begin
                                if (emit_ok) begin
                                    do_emit  = 1'b1;
                                    emit_res = err_res(ERR_TOKEN);
                                    n_count  = '0;
                                    n_err    = 1'b1;
                                    o_q_pop  = 1'b1;
                                    n_state  = st_done;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_CLOSE: begin
                if (stack_empty) begin
                    o_q_pop = 1'b1;
                    n_state = st_done;
                end else if (r_top[BRK_BIT]) begin
                    n_count = r_count - CW'(1);
                    o_q_pop = 1'b1;
                    n_state = st_done;
                end else if (emit_ok) begin
                    do_emit  = 1'b1;
                    emit_res = top_res;
                    n_count  = r_count - CW'(1);
                end
            end
            ST_FLUSH: begin
                if (!stack_empty) begin
                    if (emit_ok) begin
                        do_emit  = 1'b1;
                        emit_res = top_res;
                        n_count  = r_count - CW'(1);
                    end
                end else begin
                    n_err   = 1'b0;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_pend_v) begin
                    n_state = ST_TOKEN;
                end else if (out_free) begin
                    do_fin  = 1'b1;
                    n_state = ST_TOKEN;
                end
            end
            default: begin
                n_state = ST_TOKEN;
            end
        endcase
    end

    // one result is held back until it is known whether it closes the item
    always_comb begin
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_ov       = r_ov && !o_res.ready;
        if (do_emit) begin
            if (r_pend_v) begin
                n_out      = r_pend;
                n_out_last = 1'b0;
                n_ov       = 1'b1;
            end
            n_pend   = emit_res;
            n_pend_v = 1'b1;
        end else if (do_fin) begin
            n_out      = r_pend;
            n_out_last = 1'b1;
            n_ov       = 1'b1;
            n_pend_v   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_TOKEN;
            r_count  <= '0;
            r_err    <= 1'b0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_err    <= n_err;
            r_pend_v <= n_pend_v;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    // top of stack is kept in the read register; a push bypasses into it
    assign rd_tmp  = n_count - CW'(1);
    assign rd_addr = rd_tmp[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_count[AW-1:0]] <= wdata;
            r_top                  <= wdata;
        end else begin
            r_top <= r_mem[rd_addr];
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.out_kind   = r_out.kind;
    assign o_res.out_value  = r_out.value;
    assign o_res.error_code = r_out.err;
    assign o_res.last       = r_out_last;

endmodule
`default_nettype wire

// File: rtl/infix_to_postfix_stack_top.sv
// Infix-to-postfix token converter: top level wiring front, queue and engine.
// Depends on itp_pkg, itp_*_if, itp_front, itp_queue, itp_back.
//
// Channels: i_tok takes one classified token per beat (kind, value, end flag);
// o_res gives postfix results, last set on the final result of a token; i_cfg
// writes the packed 3-bit operator priority table (always ready).
// A token that causes no result (a push) gives no beat on o_res.
// A number goes to o_res via the pending register, then the output register.
// Each token runs a token step and a finish step; an operator or a closing
// bracket first pops operators one at a time, an end token first flushes
// the stack entry by entry, and a token ignored after an error is only dropped.
// The stack engine handles at most one stack access per cycle; a pop waits while a result is stalled.
// A 2-entry command queue lets i_tok keep accepting, until it is full, while results stall.
// Reset clears the stack count, the error latch, the queue and the priority
// table. When o_res is stalled the engine holds at most one result pending
// and then waits; nothing is dropped.
`default_nettype none
module infix_to_postfix_stack_top #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF,
    parameter int NUM_OPS     = itp_pkg::NUM_OPS_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    itp_tok_if.sink   i_tok,
    itp_cfg_if.sink   i_cfg,
    itp_res_if.source o_res
);
    import itp_pkg::*;

    logic      cmd_valid;
    t_cmd      cmd;
    logic      cmd_ready;
    logic      q_valid;
    t_cmd      q_cmd;
    logic      q_pop;
    t_prio_cfg prio;

    itp_front #(
        .NUM_OPS(NUM_OPS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (i_tok),
        .i_cfg       (i_cfg),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready),
        .o_prio      (prio)
    );

    itp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_cmd   (cmd),
        .o_ready (cmd_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    itp_back #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_prio    (prio),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule
`default_nettype wire

// File: rtl/itp_chk.sv
// Port-level checks on the converter's result channel, bound to the top.
// Depends on itp_pkg and infix_to_postfix_stack_top.
`default_nettype none
module itp_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_res_valid,
    input wire        i_res_ready,
    input wire [1:0]  i_out_kind,
    input wire [31:0] i_out_value,
    input wire [1:0]  i_error_code,
    input wire        i_last
);
    import itp_pkg::*;

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid
            && $stable({i_out_kind, i_out_value, i_error_code, i_last}))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_err_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_out_kind == OK_ERR |->
            i_error_code != ERR_NONE && i_out_value == {30'b0, i_error_code})
        else $error("malformed error report");

    a_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_out_kind != OK_ERR |-> i_error_code == ERR_NONE)
        else $error("error code on a regular result");

    a_brk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_out_kind == OK_BRK |-> i_out_value == 32'd0)
        else $error("leftover bracket with nonzero value");

endmodule

bind infix_to_postfix_stack_top itp_chk u_itp_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_out_kind   (o_res.out_kind),
    .i_out_value  (o_res.out_value),
    .i_error_code (o_res.error_code),
    .i_last       (o_res.last)
);
`default_nettype wire
